/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker bfha_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under reset disable
`define BFHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define BFHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bfha_pkg.sv */
// ---------------------------------------------------------------------------
// bfha_pkg
// Types and constants of the best-fit hole allocator.
// ---------------------------------------------------------------------------
package bfha_pkg;

  localparam int HOLE_COUNT_DEF = 64;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int IDX_OUT_W      = 6;
  localparam int REQ_W          = 16;
  localparam int SIZE_IN_W      = 16;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_ALLOCATED = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic load_en;
    logic clear;
    logic mark_en;
  } hole_ctl_t;

  // Flags of the search word handed along the chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

endpackage

/* sv/bfha_cell.sv */
// ---------------------------------------------------------------------------
// bfha_cell
// One hole of the table: its size, loaded and used bits, and one stage of
// the search chain that keeps the best candidate seen so far.
// ---------------------------------------------------------------------------
module bfha_cell import bfha_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  parameter int IDX_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hole_ctl_t            ctl,
  input  logic [IDX_W-1:0]     ctl_idx,
  input  logic [SIZE_BITS-1:0] load_size,
  input  tok_flags_t           flags_in,
  input  logic [IDX_W-1:0]     best_idx_in,
  input  logic [SIZE_BITS-1:0] best_size_in,
  input  logic [SIZE_BITS-1:0] req_size_in,
  output tok_flags_t           flags_out,
  output logic [IDX_W-1:0]     best_idx_out,
  output logic [SIZE_BITS-1:0] best_size_out,
  output logic [SIZE_BITS-1:0] req_size_out
);

  logic [SIZE_BITS-1:0] size_r;
  logic                 loaded_r, loaded_nxt;
  logic                 used_r, used_nxt;
  tok_flags_t           flags_r, flags_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_size_r, best_size_nxt;
  logic [SIZE_BITS-1:0] req_size_r;
  logic                 sel;
  logic                 take;

  assign sel = (ctl_idx == IDX_W'(INDEX));

  always_comb begin
    loaded_nxt = loaded_r;
    used_nxt   = used_r;
    if (ctl.clear) begin
      loaded_nxt = 1'b0;
      used_nxt   = 1'b0;
    end else if (ctl.load_en && sel) begin
      loaded_nxt = 1'b1;
      used_nxt   = 1'b0;
    end else if (ctl.mark_en && sel) begin
      used_nxt = 1'b1;
    end
  end

  // Strictly smaller replaces the candidate, so the lowest index wins ties
  assign take = flags_in.valid && loaded_r && !used_r && (size_r >= req_size_in) &&
                (!flags_in.found || (size_r < best_size_in));

  always_comb begin
    flags_nxt.valid = flags_in.valid;
    flags_nxt.found = flags_in.found || take;
    best_idx_nxt    = take ? IDX_W'(INDEX) : best_idx_in;
    best_size_nxt   = take ? size_r : best_size_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      used_r   <= 1'b0;
      flags_r  <= '0;
    end else begin
      loaded_r <= loaded_nxt;
      used_r   <= used_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_en && sel) begin
      size_r <= load_size;
    end
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    req_size_r  <= req_size_in;
  end

  assign flags_out     = flags_r;
  assign best_idx_out  = best_idx_r;
  assign best_size_out = best_size_r;
  assign req_size_out  = req_size_r;

endmodule

/* sv/best_fit_hole_allocator.sv */
// ---------------------------------------------------------------------------
// best_fit_hole_allocator
// Best-fit allocator over a table of hole sizes held in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Present in_cmd and in_size with start high; the word is taken at a rising
//   edge where start is high and busy is low. Commands: load a hole size,
//   request an allocation, clear the table. Code 3 is taken and dropped.
//   Each command gives one result word on out_status, out_hole_index and
//   out_request_number, marked by out_valid for exactly one cycle; the
//   receiver has no way to hold it off.
// Timing:
//   Load and clear: result strobe in the cycle after acceptance, busy stays
//   low, so one such word per cycle is taken.
//   Request: the search word walks the chain one cell per cycle through all
//   HOLE_COUNT cells while busy stays high; the result strobe is registered
//   from the last cell, busy drops in that strobe cycle and the next word can
//   be taken in it, so the length of the cell chain sets the request rate.
// Reset:
//   rst_n low empties the table, zeroes the request count, drops busy and
//   any pending strobe. Hole sizes themselves are not cleared.
// ---------------------------------------------------------------------------
module best_fit_hole_allocator import bfha_pkg::*; #(
  parameter int HOLE_COUNT = HOLE_COUNT_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [SIZE_IN_W-1:0] in_size,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [IDX_OUT_W-1:0] out_hole_index,
  output logic [REQ_W-1:0]     out_request_number
);

  localparam int IDX_W = (HOLE_COUNT > 1) ? $clog2(HOLE_COUNT) : 1;
  localparam int CNT_W = $clog2(HOLE_COUNT + 1);

  fsm_t                 state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [REQ_W-1:0]     req_cnt_r, req_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic [REQ_W-1:0]     out_reqn_r, out_reqn_nxt;

  logic                 accept;
  logic                 full;
  logic                 scan_done;
  logic [SIZE_BITS-1:0] size_in;
  logic [SIZE_BITS+SIZE_IN_W-1:0] size_ext;
  logic [IDX_W+IDX_OUT_W-1:0]     slot_ext;
  logic [IDX_W+IDX_OUT_W-1:0]     best_ext;

  hole_ctl_t            ctl;
  logic [IDX_W-1:0]     ctl_idx;

  tok_flags_t           flags    [0:HOLE_COUNT];
  logic [IDX_W-1:0]     best_idx [0:HOLE_COUNT];
  logic [SIZE_BITS-1:0] best_size[0:HOLE_COUNT];
  logic [SIZE_BITS-1:0] req_size [0:HOLE_COUNT];

  assign accept   = start && !busy;
  assign size_ext = {SIZE_BITS'(0), in_size};
  assign size_in  = size_ext[SIZE_BITS-1:0];
  assign full     = (cnt_r == CNT_W'(HOLE_COUNT));
  assign slot_ext = {IDX_OUT_W'(0), cnt_r[IDX_W-1:0]};
  assign best_ext = {IDX_OUT_W'(0), best_idx[HOLE_COUNT]};

  // Head of the chain: a fresh search word enters on an accepted request
  assign flags[0]     = '{valid: accept && (in_cmd == CMD_REQUEST), found: 1'b0};
  assign best_idx[0]  = '0;
  assign best_size[0] = '0;
  assign req_size[0]  = size_in;

  genvar gi;
  generate
    for (gi = 0; gi < HOLE_COUNT; gi++) begin : g_cell
      bfha_cell #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .INDEX     (gi)
      ) u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .ctl_idx       (ctl_idx),
        .load_size     (size_in),
        .flags_in      (flags[gi]),
        .best_idx_in   (best_idx[gi]),
        .best_size_in  (best_size[gi]),
        .req_size_in   (req_size[gi]),
        .flags_out     (flags[gi+1]),
        .best_idx_out  (best_idx[gi+1]),
        .best_size_out (best_size[gi+1]),
        .req_size_out  (req_size[gi+1])
      );
    end
  endgenerate

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept && (in_cmd == CMD_REQUEST)) begin
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (flags[HOLE_COUNT].valid) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy      = 1'b0;
    scan_done = 1'b0;
    case (state_r)
      FSM_IDLE: busy = 1'b0;
      FSM_SCAN: begin
        busy      = 1'b1;
        scan_done = flags[HOLE_COUNT].valid;
      end
      default: busy = 1'b0;
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    ctl.load_en = accept && (in_cmd == CMD_LOAD) && !full;
    ctl.clear   = accept && (in_cmd == CMD_CLEAR);
    ctl.mark_en = scan_done && flags[HOLE_COUNT].found;
    ctl_idx     = ctl.mark_en ? best_idx[HOLE_COUNT] : cnt_r[IDX_W-1:0];
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    req_cnt_nxt    = req_cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_reqn_nxt   = out_reqn_r;
    if (scan_done) begin
      out_valid_nxt = 1'b1;
      out_reqn_nxt  = req_cnt_r;
      req_cnt_nxt   = req_cnt_r + REQ_W'(1);
      if (flags[HOLE_COUNT].found) begin
        out_status_nxt = ST_ALLOCATED;
        out_idx_nxt    = best_ext[IDX_OUT_W-1:0];
      end else begin
        out_status_nxt = ST_NO_FIT;
        out_idx_nxt    = '0;
      end
    end else if (accept) begin
      case (in_cmd)
        CMD_LOAD: begin
          out_valid_nxt = 1'b1;
          out_reqn_nxt  = '0;
          if (full) begin
            out_status_nxt = ST_FULL;
            out_idx_nxt    = '0;
          end else begin
            out_status_nxt = ST_LOADED;
            out_idx_nxt    = slot_ext[IDX_OUT_W-1:0];
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CLEARED;
          out_idx_nxt    = '0;
          out_reqn_nxt   = '0;
          cnt_nxt        = '0;
          req_cnt_nxt    = '0;
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      req_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      req_cnt_r   <= req_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_reqn_r   <= out_reqn_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_hole_index     = out_idx_r;
  assign out_request_number = out_reqn_r;

endmodule

/* sv/bfha_checker.sv */
// ---------------------------------------------------------------------------
// bfha_checker
// Port-level checks on the best-fit hole allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfha_checker import bfha_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           in_cmd,
  input logic                 out_valid,
  input logic [2:0]           out_status,
  input logic [IDX_OUT_W-1:0] out_hole_index,
  input logic [REQ_W-1:0]     out_request_number
);

  logic req_acc;
  logic ldcl_acc;
  logic no_hole;
  logic no_req;
  logic code_ok;

  assign req_acc  = start && !busy && (in_cmd == CMD_REQUEST);
  assign ldcl_acc = start && !busy && (in_cmd == CMD_LOAD || in_cmd == CMD_CLEAR);
  assign no_hole  = out_valid && (out_status == ST_NO_FIT || out_status == ST_FULL ||
                                  out_status == ST_CLEARED);
  assign no_req   = out_valid && (out_status == ST_LOADED || out_status == ST_FULL ||
                                  out_status == ST_CLEARED);
  assign code_ok  = out_status == ST_LOADED || out_status == ST_ALLOCATED ||
                    out_status == ST_NO_FIT || out_status == ST_FULL ||
                    out_status == ST_CLEARED;

  // A request holds the block busy and gives no word in the next cycle
  `BFHA_ASSERT_NXT(a_req_busy, clk, rst_n, req_acc, busy && !out_valid, "request did not raise busy")

  // Load and clear never raise busy and always give a result word
  `BFHA_ASSERT_NXT(a_ld_nobusy, clk, rst_n, ldcl_acc, !busy && out_valid, "load or clear misbehaved")

  // Words without a hole carry index zero
  `BFHA_ASSERT_IMP(a_idx_zero, clk, rst_n, no_hole, out_hole_index == '0, "index not zero")

  // Only requests carry a request number
  `BFHA_ASSERT_IMP(a_reqn_zero, clk, rst_n, no_req, out_request_number == '0, "request number not zero")

  // Status stays within its codes
  `BFHA_ASSERT(a_status_ok, clk, rst_n, !out_valid || code_ok, "bad status code")

endmodule

bind best_fit_hole_allocator bfha_checker u_bfha_checker (.*);

/* bench/hole_alloc_checker.sv */
// ---------------------------------------------------------------------------
// hole_alloc_checker
// Watches the command and result channels of the best-fit hole allocator,
// keeps its own copy of the hole table and checks every result word in order.
// ---------------------------------------------------------------------------
module hole_alloc_checker import bfha_pkg::*; #(
  parameter int HOLE_COUNT = HOLE_COUNT_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [SIZE_IN_W-1:0] in_size,
  input  logic                 out_valid,
  input  logic [2:0]           out_status,
  input  logic [IDX_OUT_W-1:0] out_hole_index,
  input  logic [REQ_W-1:0]     out_request_number,
  output int                   fail_count,
  output int                   awaited,
  output int                   words_checked
);

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] hole_index;
    logic [REQ_W-1:0]     request_number;
  } alloc_word_t;

  logic [SIZE_BITS-1:0] hole_len [HOLE_COUNT];
  bit                   hole_taken [HOLE_COUNT];
  int                   holes_loaded = 0;
  logic [REQ_W-1:0]     req_count = '0;
  alloc_word_t          expected_words [$];
  int                   mismatches = 0;
  int                   checked = 0;

  // Apply one command to the table copy; returns 0 when no result follows
  function automatic bit run_command(input logic [1:0] cmd,
                                     input logic [SIZE_IN_W-1:0] size_in,
                                     output alloc_word_t res);
    logic [SIZE_BITS-1:0] sz;
    int best;
    bit found;
    res = '{ST_LOADED, '0, '0};
    sz = SIZE_BITS'(size_in);
    case (cmd)
      CMD_LOAD: begin
        if (holes_loaded >= HOLE_COUNT) begin
          res.status = ST_FULL;
        end else begin
          hole_len[holes_loaded] = sz;
          hole_taken[holes_loaded] = 1'b0;
          res.hole_index = IDX_OUT_W'(holes_loaded);
          holes_loaded++;
        end
        return 1'b1;
      end
      CMD_REQUEST: begin
        found = 1'b0;
        best = 0;
        // strict less-than keeps the lowest index among equal sizes
        for (int j = 0; j < holes_loaded; j++) begin
          if (!hole_taken[j] && hole_len[j] >= sz &&
              (!found || hole_len[j] < hole_len[best])) begin
            best = j;
            found = 1'b1;
          end
        end
        res.request_number = req_count;
        req_count = req_count + 1'b1;
        if (found) begin
          hole_taken[best] = 1'b1;
          res.status = ST_ALLOCATED;
          res.hole_index = IDX_OUT_W'(best);
        end else begin
          res.status = ST_NO_FIT;
        end
        return 1'b1;
      end
      CMD_CLEAR: begin
        foreach (hole_taken[i]) hole_taken[i] = 1'b0;
        holes_loaded = 0;
        req_count = '0;
        res.status = ST_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    alloc_word_t want;
    alloc_word_t next_word;
    if (!rst_n) begin
      foreach (hole_taken[i]) hole_taken[i] = 1'b0;
      holes_loaded = 0;
      req_count = '0;
      expected_words.delete();
    end else begin
      // check before taking the new command: its result is registered, so it is not on the outputs yet
      if (out_valid === 1'b1) begin
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("result with nothing awaited: status %0d index %0d request %0d",
                                  out_status, out_hole_index, out_request_number));
        end else begin
          want = expected_words.pop_front();
          if (out_status !== want.status || out_hole_index !== want.hole_index ||
              out_request_number !== want.request_number) begin
            note_mismatch($sformatf({"result %0d: expected status %s index %0d request %0d,",
                                     " got status %0d index %0d request %0d"},
                                    checked, want.status.name(), want.hole_index,
                                    want.request_number, out_status, out_hole_index,
                                    out_request_number));
          end
          checked++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (run_command(in_cmd, in_size, next_word)) begin
          expected_words.insert(expected_words.size(), next_word);
        end
      end
    end
    fail_count    <= mismatches;
    awaited       <= expected_words.size();
    words_checked <= checked;
  end

endmodule

/* bench/tb_best_fit_hole_allocator.sv */
// ---------------------------------------------------------------------------
// tb_best_fit_hole_allocator
// Drives load, request and clear words into the allocator: a directed opening
// on ties, exact fits and exhaustion, then random load-and-request sequences
// with table overfill and noise, under random start gaps.
// ---------------------------------------------------------------------------
module tb_best_fit_hole_allocator;
  import bfha_pkg::*;

  localparam int         HOLES        = HOLE_COUNT_DEF;
  localparam int         SIZE_W       = SIZE_BITS_DEF;
  localparam int         ITEM_TARGET  = 1750;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = HOLES + 8;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [1:0]           in_cmd = CMD_LOAD;
  logic [SIZE_IN_W-1:0] in_size = '0;
  logic                 busy;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [IDX_OUT_W-1:0] out_hole_index;
  logic [REQ_W-1:0]     out_request_number;
  int                   fail_count;
  int                   awaited;
  int                   words_checked;

  int          cycles = 0;
  int          n_load = 0;
  int          n_req = 0;
  int          n_clear = 0;
  int          n_ignored = 0;
  int          n_fills = 0;
  int          n_pauses = 0;
  bit          quiet = 1'b0;
  bit          narrow = 1'b0;
  logic [15:0] base = '0;
  logic [15:0] loaded_sizes [$];

  best_fit_hole_allocator #(
    .HOLE_COUNT(HOLES),
    .SIZE_BITS (SIZE_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_size           (in_size),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_hole_index    (out_hole_index),
    .out_request_number(out_request_number)
  );

  hole_alloc_checker #(
    .HOLE_COUNT(HOLES),
    .SIZE_BITS (SIZE_W)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_size           (in_size),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_hole_index    (out_hole_index),
    .out_request_number(out_request_number),
    .fail_count        (fail_count),
    .awaited           (awaited),
    .words_checked     (words_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results awaited", cycles, awaited);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Hold start high until the block takes the word; leave it high on return
  task automatic issue_word(input logic [1:0] cmd, input logic [15:0] size);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_cmd  <= cmd;
    in_size <= size;
    do @(posedge clk); while (busy !== 1'b0);
    case (cmd)
      CMD_LOAD: begin
        n_load++;
        loaded_sizes.insert(loaded_sizes.size(), size);
      end
      CMD_REQUEST: n_req++;
      CMD_CLEAR: begin
        n_clear++;
        loaded_sizes.delete();
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    n_pauses++;
    do @(posedge clk); while (awaited != 0);
  endtask

  // Narrow sequences cluster sizes so that ties and near misses are common
  function automatic logic [15:0] gap_len_draw();
    return narrow ? base + 16'($urandom_range(0, 31)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] request_size_draw();
    logic [15:0] pick;
    int roll;
    roll = $urandom_range(0, 3);
    if (loaded_sizes.size() == 0 || roll == 3) return gap_len_draw();
    pick = loaded_sizes[$urandom_range(0, loaded_sizes.size() - 1)];
    if (roll == 1) return pick + 16'd1;
    if (roll == 2) return pick - 16'd1;
    return pick;
  endfunction

  task automatic run_sequence(input bit fill);
    int holes;
    int asks;
    narrow = 1'($urandom_range(0, 1));
    base = 16'($urandom_range(0, 65504));
    quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) issue_word(CMD_CLEAR, 16'($urandom));
    // overfill: loads past the table depth must report table full
    holes = fill ? HOLES + $urandom_range(1, 3) : $urandom_range(1, 10);
    asks = fill ? $urandom_range(4, 16) : $urandom_range(1, holes + 3);
    for (int k = 0; k < holes; k++) issue_word(CMD_LOAD, gap_len_draw());
    for (int k = 0; k < asks; k++) begin
      if ($urandom_range(0, 5) == 0) issue_word(CMD_LOAD, gap_len_draw());
      if ($urandom_range(0, 19) == 0) issue_word(CMD_UNUSED, 16'($urandom));
      issue_word(CMD_REQUEST, request_size_draw());
    end
    if (fill) n_fills++;
  endtask

  task automatic run_noise();
    quiet = 1'b0;
    repeat ($urandom_range(1, 6)) issue_word(2'($urandom_range(0, 3)), 16'($urandom));
  endtask

  initial begin
    int seq;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // request against an empty table
    issue_word(CMD_REQUEST, 16'd0);
    issue_word(CMD_LOAD, 16'd100);
    issue_word(CMD_LOAD, 16'hFFFF);
    issue_word(CMD_LOAD, 16'd0);
    issue_word(CMD_LOAD, 16'd100);
    issue_word(CMD_LOAD, 16'h5555);
    issue_word(CMD_LOAD, 16'hAAAA);
    // equal sizes: lowest index first, then the twin
    issue_word(CMD_REQUEST, 16'd100);
    issue_word(CMD_REQUEST, 16'd99);
    issue_word(CMD_REQUEST, 16'd101);
    issue_word(CMD_REQUEST, 16'd0);
    issue_word(CMD_REQUEST, 16'hFFFF);
    issue_word(CMD_REQUEST, 16'hAAAB);
    issue_word(CMD_REQUEST, 16'hAAAA);
    // every hole used now
    issue_word(CMD_REQUEST, 16'd1);
    issue_word(CMD_UNUSED, 16'hFFFF);
    issue_word(CMD_CLEAR, 16'h0000);
    issue_word(CMD_REQUEST, 16'd0);
    issue_word(CMD_LOAD, 16'h8000);
    issue_word(CMD_REQUEST, 16'h7FFF);
    issue_word(CMD_CLEAR, 16'hFFFF);
    drain();

    seq = 0;
    while (n_load + n_req + n_clear < ITEM_TARGET) begin
      if (seq == 0 || $urandom_range(0, 3) == 0) drain();
      if (seq != 0 && $urandom_range(0, 6) == 0) run_noise();
      else run_sequence(seq == 0 || $urandom_range(0, 11) == 0);
      seq++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d words: %0d loads, %0d requests, %0d clears, %0d unused codes",
             n_load + n_req + n_clear + n_ignored, n_load, n_req, n_clear, n_ignored);
    $display("%0d results checked; table overfilled in %0d sequences; %0d drain pauses",
             words_checked, n_fills, n_pauses);
    if (fail_count == 0 && awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, awaited);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/bfha_pkg.sv
sv/bfha_cell.sv
sv/best_fit_hole_allocator.sv
sv/bfha_checker.sv
bench/hole_alloc_checker.sv
bench/tb_best_fit_hole_allocator.sv
